// ----- hw/rtl/qbrd_pkg.sv -----
// Shared package of the quadtree bitmap region decoder.
// Symbol codes, register indexes and the stack command record.
// No dependencies.
`default_nettype none

package qbrd_pkg;

    // Code symbols
    localparam logic [1:0] SYM_ZERO    = 2'd0;
    localparam logic [1:0] SYM_ONE     = 2'd1;
    localparam logic [1:0] SYM_DIVIDE  = 2'd2;
    localparam logic [1:0] SYM_UNUSED  = 2'd3;

    // Configuration register indexes
    localparam logic REG_ROW_COUNT = 1'b0;
    localparam logic REG_COL_COUNT = 1'b1;

    // Push slots, in push order (last one ends on top)
    localparam int PUSH_BR = 0;
    localparam int PUSH_BL = 1;
    localparam int PUSH_TR = 2;
    localparam int PUSH_TL = 3;
    localparam int PUSH_SLOTS = 4;

    // One stack update per accepted symbol other than SYM_UNUSED
    typedef struct packed {
        logic       step;     // apply this update at the clock edge
        logic       pop;      // remove the top entry first
        logic [3:0] push_en;  // slots to push, indexed by PUSH_*
    } t_stack_cmd;

endpackage

`default_nettype wire

// ----- hw/rtl/qbrd_region_stack.sv -----
// Register-file stack of pending rectangles for the region decoder.
// One pop and up to four pushes per cycle; uses qbrd_pkg.
// Full-stack pushes are discarded, matching the decode order.
`default_nettype none

module qbrd_region_stack
    import qbrd_pkg::*;
#(
    parameter int CW    = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire t_stack_cmd                     i_cmd,
    input  wire logic [PUSH_SLOTS-1:0][4*CW-1:0] i_push_rect,
    output logic                                o_empty,
    output logic                                o_next_empty,
    output logic [4*CW-1:0]                     o_top
);

    localparam int LW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam int PW = LW + 2;

    logic [4*CW-1:0] r_mem [DEPTH];
    logic [LW-1:0]   r_level;
    logic [LW-1:0]   n_level;

    logic [LW-1:0]   base;
    logic [LW-1:0]   top_level;
    logic [PW-1:0]   pos [PUSH_SLOTS];
    logic [PUSH_SLOTS-1:0] wr;
    logic [PW-1:0]   fill;

    assign o_empty   = (r_level == '0);
    assign top_level = r_level - LW'(1);
    assign o_top     = r_mem[top_level[IW-1:0]];

    // Slot positions above the popped level
    always_comb begin
        logic [PW-1:0] run;
        base = i_cmd.pop ? top_level : r_level;
        run  = PW'(base);
        for (int k = 0; k < PUSH_SLOTS; k++) begin
            pos[k] = run;
            wr[k]  = i_cmd.push_en[k] && (run < PW'(DEPTH));
            run    = run + PW'(i_cmd.push_en[k]);
        end
        fill = run;
    end

    // Level after this update, saturated at the depth
    always_comb begin
        if (fill > PW'(DEPTH)) begin
            n_level = LW'(DEPTH);
        end else begin
            n_level = fill[LW-1:0];
        end
    end

    assign o_next_empty = (n_level == '0);

    // Level counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
        end else if (i_cmd.step) begin
            r_level <= n_level;
        end
    end

    // Entry writes; positions of enabled slots are distinct
    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            for (int i = 0; i < DEPTH; i++) begin
                for (int k = 0; k < PUSH_SLOTS; k++) begin
                    if (wr[k] && (pos[k] == PW'(i))) begin
                        r_mem[i] <= i_push_rect[k];
                    end
                end
            end
        end
    end

    // Checks
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= LW'(DEPTH))
        else $error("stack level above depth");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step && i_cmd.pop |-> !o_empty)
        else $error("pop from empty stack");

    a_pop_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step && i_cmd.pop && (i_cmd.push_en == '0)
        |=> r_level == $past(r_level) - LW'(1))
        else $error("pop without push did not lower level by one");

    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.step |=> $stable(r_level))
        else $error("stack level moved without a step");

endmodule

`default_nettype wire

// ----- hw/rtl/quadtree_bitmap_region_decoder.sv -----
// Quadtree bitmap region decoder, top level.
// Depends on qbrd_pkg and qbrd_region_stack.
//
// Usage:
//   Input channel (i_valid/o_ready, i_symbol) takes one code symbol per
//   transfer: 0 and 1 are leaves, 2 divides the current rectangle, 3 is
//   ignored. Output channel (o_valid/i_ready) delivers one filled rectangle
//   per leaf, or a flagged single cell for a divide that cannot split.
//   Each result shows in the cycle after its symbol transfer. A symbol is taken
//   every cycle: the pending-rectangle stack pops and pushes up to four
//   parts in the same cycle, and the midpoint math is one add and shift.
//   While the receiver stalls, the output register holds its result and a
//   new symbol is taken only in a cycle in which that register drains.
//   o_image_done marks the last rectangle of an image; the next symbol
//   starts a new image from the row and column count registers, which are
//   clamped to 1..MAX_DIM and sampled only at image start.
//   Reset empties the stack (no clearing pass: entries above the level are
//   never read), sets both counts to 1 and drops any held result.
//   Configuration: i_cfg_we writes i_cfg_wdata to register i_cfg_addr
//   (0 = row count, 1 = column count) in that cycle.
`default_nettype none

module quadtree_bitmap_region_decoder
    import qbrd_pkg::*;
#(
    parameter int MAX_DIM     = 256,
    parameter int STACK_DEPTH = 32
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // symbol input
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [1:0] i_symbol,
    // rectangle output
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [7:0]      o_row_first,
    output logic [7:0]      o_col_first,
    output logic [7:0]      o_row_last,
    output logic [7:0]      o_col_last,
    output logic            o_pixel_value,
    output logic            o_image_done,
    output logic            o_malformed,
    // configuration
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_addr,
    input  wire logic [8:0] i_cfg_wdata
);

    localparam int CW = $clog2(MAX_DIM);

    logic [8:0] r_row_count;
    logic [8:0] r_col_count;

    logic            r_out_valid;
    logic [7:0]      r_row_first, r_col_first, r_row_last, r_col_last;
    logic            r_pixel, r_done, r_bad;

    t_stack_cmd      cmd;
    logic [PUSH_SLOTS-1:0][4*CW-1:0] push_rect;
    logic            stk_empty, stk_next_empty;
    logic [4*CW-1:0] stk_top;

    logic            accept;
    logic [CW-1:0]   r0, c0, r1, c1;
    logic [CW-1:0]   rm, cm, rm1, cm1;
    logic [CW:0]     rsum, csum;
    logic            wide, tall, single, is_div, is_leaf, has_res;

    // Count register to last coordinate, clamped to 1..MAX_DIM
    function automatic logic [CW-1:0] last_coord(input logic [8:0] v);
        logic [CW-1:0] d;
        if (v == '0) begin
            d = '0;
        end else if (32'(v) > MAX_DIM) begin
            d = CW'(MAX_DIM - 1);
        end else begin
            d = CW'(32'(v) - 32'd1);
        end
        return d;
    endfunction

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= 9'd1;
            r_col_count <= 9'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_ROW_COUNT: r_row_count <= i_cfg_wdata;
                REG_COL_COUNT: r_col_count <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;

    // Current rectangle: whole image or stack top
    always_comb begin
        if (stk_empty) begin
            r0 = '0;
            c0 = '0;
            r1 = last_coord(r_row_count);
            c1 = last_coord(r_col_count);
        end else begin
            {r0, c0, r1, c1} = stk_top;
        end
    end

    // Split geometry
    assign wide   = (c0 != c1);
    assign tall   = (r0 != r1);
    assign single = !wide && !tall;
    assign rsum   = {1'b0, r0} + {1'b0, r1};
    assign csum   = {1'b0, c0} + {1'b0, c1};
    assign rm     = rsum[CW:1];
    assign cm     = csum[CW:1];
    assign rm1    = rm + CW'(1);
    assign cm1    = cm + CW'(1);

    assign is_div  = (i_symbol == SYM_DIVIDE);
    assign is_leaf = (i_symbol == SYM_ZERO) || (i_symbol == SYM_ONE);
    assign has_res = accept && (is_leaf || (is_div && single));

    // Stack command and parts, pushed bottom-right first
    always_comb begin
        cmd.step = accept && (i_symbol != SYM_UNUSED);
        cmd.pop  = !stk_empty;
        cmd.push_en = '0;
        if (is_div && !single) begin
            cmd.push_en[PUSH_BR] = wide && tall;
            cmd.push_en[PUSH_BL] = tall;
            cmd.push_en[PUSH_TR] = wide;
            cmd.push_en[PUSH_TL] = 1'b1;
        end
        push_rect[PUSH_BR] = {rm1, cm1, r1, c1};
        push_rect[PUSH_BL] = {rm1, c0, r1, cm};
        push_rect[PUSH_TR] = {r0, cm1, rm, c1};
        push_rect[PUSH_TL] = {r0, c0, rm, cm};
    end

    qbrd_region_stack #(
        .CW    (CW),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_push_rect  (push_rect),
        .o_empty      (stk_empty),
        .o_next_empty (stk_next_empty),
        .o_top        (stk_top)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (has_res) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (has_res) begin
            r_row_first <= 8'(r0);
            r_col_first <= 8'(c0);
            r_row_last  <= 8'(r1);
            r_col_last  <= 8'(c1);
            r_pixel     <= is_leaf && i_symbol[0];
            r_done      <= stk_next_empty;
            r_bad       <= is_div;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_row_first   = r_row_first;
    assign o_col_first   = r_col_first;
    assign o_row_last    = r_row_last;
    assign o_col_last    = r_col_last;
    assign o_pixel_value = r_pixel;
    assign o_image_done  = r_done;
    assign o_malformed   = r_bad;

    // Checks
    a_bad_is_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_malformed |-> !o_pixel_value && (o_row_first == o_row_last)
            && (o_col_first == o_col_last))
        else $error("malformed result is not a single zero cell");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        has_res |=> o_valid)
        else $error("result of accepted symbol missing");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable({o_row_first, o_col_first,
            o_row_last, o_col_last, o_pixel_value, o_image_done, o_malformed}))
        else $error("stalled result changed or dropped");

endmodule

`default_nettype wire
